// ===== rtl/mpasm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpasm_pkg
// shared types and constants of the wide integer add, subtract and multiply unit
// ----------------------------------------------------------------------------
package mpasm_pkg;

	localparam int LIMB_W    = 64;
	localparam int WORD_W    = 256;
	localparam int DIG_W     = 32;
	localparam int NUM_DIGS  = WORD_W / DIG_W;
	localparam int NUM_CELLS = NUM_DIGS;

	localparam logic [1:0] PREC_64  = 2'd0;
	localparam logic [1:0] PREC_128 = 2'd1;
	localparam logic [1:0] PREC_256 = 2'd2;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2
	} func_t;

	typedef struct packed {
		logic              valid;
		logic              mul;
		logic [1:0]        prec;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} cell_bus_t;

endpackage

// ===== rtl/multi_precision_add_sub_mul.sv =====
// ----------------------------------------------------------------------------
// multi_precision_add_sub_mul
// wide unsigned add, subtract and multiply at 64, 128 or 256 bits
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries the operation, two operands of
//   four 64-bit limbs and a precision tag for each operand. The result channel
//   out_valid / out_stall returns the result limbs and the result precision,
//   the larger of the two tags; limbs above that width read zero.
//   An item is taken at each edge with valid high and stall low.
//   The pipeline is an input register, eight multiply cells of two stages
//   each (one 32-bit digit of a per cell) and an output register.
//   One item per cycle unless stalled; every item walks the whole cell chain.
//   While the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised; items already inside are kept, none is lost.
//   Reset empties the pipeline; no result is pending after reset.
// ----------------------------------------------------------------------------
module multi_precision_add_sub_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  a_prec,
	input  logic [1:0]  b_prec,
	input  logic [63:0] a_limb0,
	input  logic [63:0] a_limb1,
	input  logic [63:0] a_limb2,
	input  logic [63:0] a_limb3,
	input  logic [63:0] b_limb0,
	input  logic [63:0] b_limb1,
	input  logic [63:0] b_limb2,
	input  logic [63:0] b_limb3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  res_prec,
	output logic [63:0] res_limb0,
	output logic [63:0] res_limb1,
	output logic [63:0] res_limb2,
	output logic [63:0] res_limb3
);

	logic                          en;
	logic [1:0]                    ap;
	logic [1:0]                    bp;
	logic [mpasm_pkg::WORD_W-1:0]  a_ext;
	logic [mpasm_pkg::WORD_W-1:0]  b_ext;
	mpasm_pkg::cell_bus_t          bus_in;
	logic                          valid_q;
	logic                          mul_q;
	logic [1:0]                    prec_q;
	logic [mpasm_pkg::WORD_W-1:0]  acc_q;
	logic [mpasm_pkg::WORD_W-1:0]  a_q;
	logic [mpasm_pkg::WORD_W-1:0]  b_q;
	mpasm_pkg::cell_bus_t          chain [mpasm_pkg::NUM_CELLS+1];
	mpasm_pkg::cell_bus_t          last;
	logic                          out_valid_q;
	logic [1:0]                    res_prec_q;
	logic [mpasm_pkg::WORD_W-1:0]  res_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = out_valid_q && out_stall;

	// unused tag three counts as full width
	always_comb begin
		ap = (a_prec > mpasm_pkg::PREC_256) ? mpasm_pkg::PREC_256 : a_prec;
		bp = (b_prec > mpasm_pkg::PREC_256) ? mpasm_pkg::PREC_256 : b_prec;
		a_ext = '0;
		b_ext = '0;
		a_ext[63:0] = a_limb0;
		b_ext[63:0] = b_limb0;
		if (ap != mpasm_pkg::PREC_64) begin
			a_ext[127:64] = a_limb1;
		end
		if (bp != mpasm_pkg::PREC_64) begin
			b_ext[127:64] = b_limb1;
		end
		if (ap == mpasm_pkg::PREC_256) begin
			a_ext[255:128] = {a_limb3, a_limb2};
		end
		if (bp == mpasm_pkg::PREC_256) begin
			b_ext[255:128] = {b_limb3, b_limb2};
		end

		bus_in.valid = in_valid;
		bus_in.prec  = (ap > bp) ? ap : bp;
		bus_in.a     = a_ext;
		bus_in.b     = b_ext;
		bus_in.mul   = 1'b0;
		bus_in.acc   = '0;
		unique case (func)
			mpasm_pkg::FUNC_ADD: bus_in.acc = a_ext + b_ext;
			mpasm_pkg::FUNC_SUB: bus_in.acc = a_ext - b_ext;
			mpasm_pkg::FUNC_MUL: bus_in.mul = 1'b1;
			default:             bus_in.acc = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= bus_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_q  <= bus_in.mul;
			prec_q <= bus_in.prec;
			acc_q  <= bus_in.acc;
			a_q    <= bus_in.a;
			b_q    <= bus_in.b;
		end
	end

	assign chain[0] = {valid_q, mul_q, prec_q, acc_q, a_q, b_q};

	for (genvar i = 0; i < mpasm_pkg::NUM_CELLS; i++) begin : g_cell
		mpasm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	assign last = chain[mpasm_pkg::NUM_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	// clear limbs above the result width
	always_ff @(posedge clk) begin
		if (en) begin
			res_prec_q      <= last.prec;
			res_q[63:0]     <= last.acc[63:0];
			res_q[127:64]   <= (last.prec != mpasm_pkg::PREC_64) ? last.acc[127:64] : '0;
			res_q[255:128]  <= (last.prec == mpasm_pkg::PREC_256) ? last.acc[255:128] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign res_prec  = res_prec_q;
	assign res_limb0 = res_q[63:0];
	assign res_limb1 = res_q[127:64];
	assign res_limb2 = res_q[191:128];
	assign res_limb3 = res_q[255:192];

endmodule

// ===== rtl/mpasm_cell.sv =====
// ----------------------------------------------------------------------------
// mpasm_cell
// one digit of the multiply chain: 32-bit digit of a times b, added to the sum
// ----------------------------------------------------------------------------
module mpasm_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  mpasm_pkg::cell_bus_t  din,
	output mpasm_pkg::cell_bus_t  dout
);

	logic [mpasm_pkg::NUM_DIGS-1:0][2*mpasm_pkg::DIG_W-1:0] prod_s1;
	logic                          valid_s1;
	logic                          mul_s1;
	logic [1:0]                    prec_s1;
	logic [mpasm_pkg::WORD_W-1:0]  acc_s1;
	logic [mpasm_pkg::WORD_W-1:0]  a_s1;
	logic [mpasm_pkg::WORD_W-1:0]  b_s1;

	logic [mpasm_pkg::WORD_W-1:0]  even_sum;
	logic [mpasm_pkg::WORD_W-1:0]  odd_sum;
	logic [mpasm_pkg::WORD_W-1:0]  sum;

	logic                          valid_s2;
	logic                          mul_s2;
	logic [1:0]                    prec_s2;
	logic [mpasm_pkg::WORD_W-1:0]  acc_s2;
	logic [mpasm_pkg::WORD_W-1:0]  a_s2;
	logic [mpasm_pkg::WORD_W-1:0]  b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
			valid_s2 <= valid_s1;
		end
	end

	// partial products of one digit of a against every digit of b
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < mpasm_pkg::NUM_DIGS; j++) begin
				if (din.mul) begin
					prod_s1[j] <= (2*mpasm_pkg::DIG_W)'(din.a[mpasm_pkg::DIG_W-1:0])
						* (2*mpasm_pkg::DIG_W)'(din.b[j*mpasm_pkg::DIG_W +: mpasm_pkg::DIG_W]);
				end else begin
					prod_s1[j] <= '0;
				end
			end
			mul_s1  <= din.mul;
			prec_s1 <= din.prec;
			acc_s1  <= din.acc;
			a_s1    <= din.a >> mpasm_pkg::DIG_W;
			b_s1    <= din.b << mpasm_pkg::DIG_W;
		end
	end

	always_comb begin
		even_sum = '0;
		odd_sum  = '0;
		for (int j = 0; j < mpasm_pkg::NUM_DIGS; j += 2) begin
			even_sum[j*mpasm_pkg::DIG_W +: 2*mpasm_pkg::DIG_W] = prod_s1[j];
			odd_sum[j*mpasm_pkg::DIG_W +: 2*mpasm_pkg::DIG_W]  = prod_s1[j+1];
		end
		sum = acc_s1 + even_sum + (odd_sum << mpasm_pkg::DIG_W);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s2  <= mul_s1;
			prec_s2 <= prec_s1;
			acc_s2  <= sum;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
		end
	end

	assign dout = {valid_s2, mul_s2, prec_s2, acc_s2, a_s2, b_s2};

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wide add, subtract and multiply unit: directed
// corner operands then random items, every result checked against a local
// 256-bit predictor, with random idling on both sides and one long hold-off
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic [1:0]   fn;
		logic [1:0]   ap;
		logic [1:0]   bp;
		logic [255:0] a;
		logic [255:0] b;
	} op_t;

	typedef struct {
		logic [1:0]   prec;
		logic [255:0] val;
	} sum_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [1:0]  a_prec = '0;
	logic [1:0]  b_prec = '0;
	logic [63:0] a_limb0 = '0, a_limb1 = '0, a_limb2 = '0, a_limb3 = '0;
	logic [63:0] b_limb0 = '0, b_limb1 = '0, b_limb2 = '0, b_limb3 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  res_prec;
	logic [63:0] res_limb0, res_limb1, res_limb2, res_limb3;

	op_t    pending_ops[$];
	sum_t   expected_sums[$];
	bit     stim_done = 1'b0;
	int     errors = 0;
	int     idle_cycles = 0;
	int     send_gap = 0;
	int     recv_gap = 0;
	int     accepted_in = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;

	multi_precision_add_sub_mul u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [255:0] zext(logic [255:0] v, logic [1:0] p);
		if (p == mpasm_pkg::PREC_64)
			return {192'd0, v[63:0]};
		else if (p == mpasm_pkg::PREC_128)
			return {128'd0, v[127:0]};
		return v;
	endfunction

	function automatic sum_t compute_sum(op_t o);
		sum_t s;
		logic [1:0] ap, bp;
		logic [255:0] x, y, r;
		ap = (o.ap >= mpasm_pkg::PREC_256) ? mpasm_pkg::PREC_256 : o.ap;
		bp = (o.bp >= mpasm_pkg::PREC_256) ? mpasm_pkg::PREC_256 : o.bp;
		s.prec = (ap > bp) ? ap : bp;
		x = zext(o.a, ap);
		y = zext(o.b, bp);
		case (o.fn)
			mpasm_pkg::FUNC_ADD: r = x + y;
			mpasm_pkg::FUNC_SUB: r = x - y;
			mpasm_pkg::FUNC_MUL: r = x * y;
			default: r = '0;
		endcase
		s.val = zext(r, s.prec);
		return s;
	endfunction

	function automatic logic [255:0] rnd_word();
		logic [255:0] v;
		for (int i = 0; i < 8; i++)
			v[i*32 +: 32] = $urandom;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = v >> $urandom_range(0, 255);
			3: v = v | ({256{1'b1}} << $urandom_range(0, 255));
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		op_t o;
		logic [255:0] corner[4];
		corner[0] = '0;
		corner[1] = '1;
		corner[2] = 256'd1;
		corner[3] = {1'b1, 255'd0};
		for (int f = 0; f < 4; f++)
			for (int k = 0; k < 4; k++) begin
				o.fn = 2'(f);
				o.ap = 2'(k);
				o.bp = 2'(3 - k);
				o.a = corner[k];
				o.b = corner[(k + f) % 4];
				pending_ops.push_back(o);
			end
		for (int p = 0; p < 3; p++) begin
			o.fn = mpasm_pkg::FUNC_MUL;
			o.ap = 2'(p);
			o.bp = 2'(p);
			o.a = '1;
			o.b = '1;
			pending_ops.push_back(o);
			o.fn = mpasm_pkg::FUNC_ADD;
			pending_ops.push_back(o);
			o.fn = mpasm_pkg::FUNC_SUB;
			o.a = '0;
			o.b = 256'd1;
			pending_ops.push_back(o);
		end
		for (int n = 0; n < 1330; n++) begin
			o.fn = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			o.ap = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			o.bp = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			o.a = rnd_word();
			o.b = rnd_word();
			pending_ops.push_back(o);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		op_t o;
		if (arst_n && !stim_done) begin
			if (in_valid && !in_stall) begin
				expected_sums.push_back(compute_sum(pending_ops.pop_front()));
				accepted_in <= accepted_in + 1;
				send_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					send_gap = 0;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_ops.size() == 0) begin
					in_valid <= 1'b0;
					stim_done <= 1'b1;
				end else if (send_gap > 0 || (accepted_in > 600 && accepted_in < 700
						&& send_gap > 0)) begin
					send_gap--;
					in_valid <= 1'b0;
				end else begin
					o = pending_ops[0];
					in_valid <= 1'b1;
					func <= o.fn;
					a_prec <= o.ap;
					b_prec <= o.bp;
					{a_limb3, a_limb2, a_limb1, a_limb0} <= o.a;
					{b_limb3, b_limb2, b_limb1, b_limb0} <= o.b;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		sum_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					$error("unexpected item: prec %0d", res_prec);
					errors++;
				end else begin
					e = expected_sums.pop_front();
					if (res_prec !== e.prec) begin
						$error("res_prec: expected %0d, got %0d", e.prec, res_prec);
						errors++;
					end
					if (res_limb0 !== e.val[63:0]) begin
						$error("res_limb0: expected %h, got %h", e.val[63:0], res_limb0);
						errors++;
					end
					if (res_limb1 !== e.val[127:64]) begin
						$error("res_limb1: expected %h, got %h", e.val[127:64], res_limb1);
						errors++;
					end
					if (res_limb2 !== e.val[191:128]) begin
						$error("res_limb2: expected %h, got %h", e.val[191:128], res_limb2);
						errors++;
					end
					if (res_limb3 !== e.val[255:192]) begin
						$error("res_limb3: expected %h, got %h", e.val[255:192], res_limb3);
						errors++;
					end
				end
				recv_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					recv_gap = 0;
			end
			if (!hold_done && accepted_in >= 500) begin
				hold_done = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (stim_done && expected_sums.size() == 0 && idle_cycles > 40) begin
			if (errors == 0)
				$display("RESULT: OK");
			else
				$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/mpasm_pkg.sv
rtl/mpasm_cell.sv
rtl/multi_precision_add_sub_mul.sv
bench/tb.sv
